// ===== src/sdicp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdicp_pkg
// Shared types and character constants for the slash-delimited command parser.
// ----------------------------------------------------------------------------
package sdicp_pkg;

  localparam int unsigned ACCUM_W  = 30;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned FIELDS_W = 6;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_IDLE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ACCUM_W-1:0] accum;
    logic               negative;
    phase_e             phase;
  } field_t;

  localparam field_t FIELD_CLEAR = '{accum: '0, negative: 1'b0, phase: PH_SKIP};

endpackage

// ===== src/slash_delimited_int_command_parser.sv =====
// ----------------------------------------------------------------------------
// slash_delimited_int_command_parser
// Parses "a/b/.../n\n" signed decimal commands and updates held values on idle.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while no result waits untaken, the
//   field update (multiply by ten and add) being combinational between the field registers.
// Result: a line-idle transaction yields its result in the output register
//   in the cycle after acceptance; byte transactions yield no result.
// Reset: rst_ni clears all command state, the held values and the output slot.
// ----------------------------------------------------------------------------
module slash_delimited_int_command_parser #(
  parameter int unsigned FIELD_CHARS = 9,
  parameter int unsigned MAX_FIELDS  = 50
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                updated_o,
  output logic signed [sdicp_pkg::VALUE_W-1:0] pred_time_o,
  output logic signed [sdicp_pkg::VALUE_W-1:0] assist_tenths_o,
  output logic [sdicp_pkg::FIELDS_W-1:0]      fields_seen_o
);

  localparam int unsigned CH_W  = $clog2(FIELD_CHARS + 1);
  localparam int unsigned CNT_W = $clog2(MAX_FIELDS + 1);

  sdicp_pkg::field_t             field_q, field_d, field_byte;
  logic [CH_W-1:0]               chars_q, chars_d, chars_byte;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          zero_seen_q, zero_seen_d;
  logic                          line_done_q, line_done_d;
  logic [sdicp_pkg::VALUE_W-1:0] first_q, first_d, second_q, second_d;
  logic [sdicp_pkg::VALUE_W-1:0] held_pred_q, held_pred_d, held_asst_q, held_asst_d;
  logic                          out_valid_q, out_valid_d;
  logic                          updated_q, updated_d;
  logic [CNT_W-1:0]              seen_q, seen_d;

  logic                          in_fire;
  logic                          is_idle;
  logic                          upd;
  logic [sdicp_pkg::VALUE_W-1:0] mag;
  logic [sdicp_pkg::VALUE_W-1:0] value;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_idle    = (action_i == sdicp_pkg::ACT_IDLE);

  sdicp_field #(
    .FIELD_CHARS(FIELD_CHARS),
    .CH_W       (CH_W)
  ) u_field (
    .field_i(field_q),
    .chars_i(chars_q),
    .byte_i (rx_byte_i),
    .field_o(field_byte),
    .chars_o(chars_byte)
  );

  assign mag   = {1'b0, field_q.accum};
  assign value = field_q.negative ? (sdicp_pkg::VALUE_W'(0) - mag) : mag;
  assign upd   = (count_q != '0) && !zero_seen_q;

  always_comb begin
    field_d     = field_q;
    chars_d     = chars_q;
    count_d     = count_q;
    zero_seen_d = zero_seen_q;
    line_done_d = line_done_q;
    first_d     = first_q;
    second_d    = second_q;
    held_pred_d = held_pred_q;
    held_asst_d = held_asst_q;
    out_valid_d = out_valid_q && !out_ready_i;
    updated_d   = updated_q;
    seen_d      = seen_q;

    if (in_fire) begin
      if (is_idle) begin
        out_valid_d = 1'b1;
        updated_d   = upd;
        seen_d      = count_q;
        if (upd) begin
          held_pred_d = first_q;
          if (count_q >= CNT_W'(2)) begin
            held_asst_d = second_q;
          end
        end
        field_d     = sdicp_pkg::FIELD_CLEAR;
        chars_d     = '0;
        count_d     = '0;
        zero_seen_d = 1'b0;
        line_done_d = 1'b0;
        first_d     = '0;
        second_d    = '0;
      end else if (!line_done_q) begin
        if (rx_byte_i == sdicp_pkg::CHAR_SLASH || rx_byte_i == sdicp_pkg::CHAR_NL) begin
          // Close the current field; fields past the limit are not counted.
          if (count_q < CNT_W'(MAX_FIELDS)) begin
            if (count_q == '0) begin
              first_d = value;
            end else if (count_q == CNT_W'(1)) begin
              second_d = value;
            end
            if (field_q.accum == '0) begin
              zero_seen_d = 1'b1;
            end
            count_d = count_q + CNT_W'(1);
          end
          field_d = sdicp_pkg::FIELD_CLEAR;
          chars_d = '0;
          if (rx_byte_i == sdicp_pkg::CHAR_NL) begin
            line_done_d = 1'b1;
          end
        end else begin
          field_d = field_byte;
          chars_d = chars_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= sdicp_pkg::FIELD_CLEAR;
      chars_q     <= '0;
      count_q     <= '0;
      zero_seen_q <= 1'b0;
      line_done_q <= 1'b0;
      first_q     <= '0;
      second_q    <= '0;
      held_pred_q <= '0;
      held_asst_q <= '0;
      out_valid_q <= 1'b0;
      updated_q   <= 1'b0;
      seen_q      <= '0;
    end else begin
      field_q     <= field_d;
      chars_q     <= chars_d;
      count_q     <= count_d;
      zero_seen_q <= zero_seen_d;
      line_done_q <= line_done_d;
      first_q     <= first_d;
      second_q    <= second_d;
      held_pred_q <= held_pred_d;
      held_asst_q <= held_asst_d;
      out_valid_q <= out_valid_d;
      updated_q   <= updated_d;
      seen_q      <= seen_d;
    end
  end

  // The held values change only on an accepted idle transaction, which cannot
  // happen while a result waits, so they serve directly as result payload.
  assign out_valid_o     = out_valid_q;
  assign updated_o       = updated_q;
  assign pred_time_o     = held_pred_q;
  assign assist_tenths_o = held_asst_q;
  assign fields_seen_o   = sdicp_pkg::FIELDS_W'(seen_q);

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_FIELDS))
    else $error("field count exceeds the limit");

  a_chars_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= CH_W'(FIELD_CHARS))
    else $error("field character count exceeds the limit");

  a_idle_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_idle) |=> (count_q == '0) && !line_done_q && !zero_seen_q && out_valid_q)
    else $error("idle transaction did not clear command state");

  a_update_needs_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && updated_o) |-> (fields_seen_o != '0))
    else $error("update reported with no fields");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && is_idle) |=> $stable(held_pred_q) && $stable(held_asst_q))
    else $error("held values changed without an idle transaction");

endmodule

// ===== src/sdicp_field.sv =====
// ----------------------------------------------------------------------------
// sdicp_field
// Next-state logic of one field for an ordinary byte (not '/' or newline).
// ----------------------------------------------------------------------------
module sdicp_field #(
  parameter int unsigned FIELD_CHARS = 9,
  parameter int unsigned CH_W        = 4
) (
  input  sdicp_pkg::field_t field_i,
  input  logic [CH_W-1:0]   chars_i,
  input  logic [7:0]        byte_i,
  output sdicp_pkg::field_t field_o,
  output logic [CH_W-1:0]   chars_o
);

  logic                          is_digit;
  logic                          is_space;
  logic [3:0]                    digit;
  logic [sdicp_pkg::ACCUM_W-1:0] times_ten;

  assign is_digit  = (byte_i >= sdicp_pkg::CHAR_ZERO) && (byte_i <= sdicp_pkg::CHAR_NINE);
  assign is_space  = (byte_i == sdicp_pkg::CHAR_SPACE) ||
                     ((byte_i >= sdicp_pkg::CHAR_TAB) && (byte_i <= sdicp_pkg::CHAR_CR));
  assign digit     = byte_i[3:0];
  assign times_ten = (field_i.accum << 3) + (field_i.accum << 1);

  always_comb begin
    field_o = field_i;
    chars_o = chars_i;
    // Bytes past the field length limit are dropped entirely.
    if (chars_i < CH_W'(FIELD_CHARS)) begin
      chars_o = chars_i + CH_W'(1);
      unique case (field_i.phase)
        sdicp_pkg::PH_SKIP: begin
          if (is_space) begin
            field_o.phase = sdicp_pkg::PH_SKIP;
          end else if (byte_i == sdicp_pkg::CHAR_PLUS) begin
            field_o.phase = sdicp_pkg::PH_DIGITS;
          end else if (byte_i == sdicp_pkg::CHAR_MINUS) begin
            field_o.negative = 1'b1;
            field_o.phase    = sdicp_pkg::PH_DIGITS;
          end else if (is_digit) begin
            field_o.accum = sdicp_pkg::ACCUM_W'(digit);
            field_o.phase = sdicp_pkg::PH_DIGITS;
          end else begin
            field_o.phase = sdicp_pkg::PH_DONE;
          end
        end
        sdicp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            field_o.accum = times_ten + sdicp_pkg::ACCUM_W'(digit);
          end else begin
            field_o.phase = sdicp_pkg::PH_DONE;
          end
        end
        sdicp_pkg::PH_DONE: begin
          field_o.phase = sdicp_pkg::PH_DONE;
        end
        default: begin
          field_o.phase = sdicp_pkg::PH_DONE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sdicp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdicp_checker
// Watches both channels of the command parser, keeps its own copy of the
// parse state, and compares every result transaction with the expected one.
// ----------------------------------------------------------------------------
module sdicp_checker #(
  parameter int unsigned FIELD_CHARS = 9,
  parameter int unsigned MAX_FIELDS  = 50
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic                                 action_i,
  input  logic [7:0]                           rx_byte_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic                                 updated_i,
  input  logic signed [sdicp_pkg::VALUE_W-1:0] pred_time_i,
  input  logic signed [sdicp_pkg::VALUE_W-1:0] assist_tenths_i,
  input  logic [sdicp_pkg::FIELDS_W-1:0]       fields_seen_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   results_checked_o,
  output int                                   updates_seen_o
);

  typedef struct {
    logic                           updated;
    logic [sdicp_pkg::VALUE_W-1:0]  predict;
    logic [sdicp_pkg::VALUE_W-1:0]  assist;
    logic [sdicp_pkg::FIELDS_W-1:0] fields;
  } status_t;

  status_t status_q[$];

  // Parse state of the command being received.
  logic [sdicp_pkg::ACCUM_W-1:0]  digits_acc;
  logic                           minus_sign;
  sdicp_pkg::phase_e              phase;
  logic [3:0]                     kept_chars;
  logic [sdicp_pkg::FIELDS_W-1:0] nfields;
  logic                           saw_zero;
  logic                           newline_seen;
  logic [sdicp_pkg::VALUE_W-1:0]  field1;
  logic [sdicp_pkg::VALUE_W-1:0]  field2;
  // Values that survive from one command to the next.
  logic [sdicp_pkg::VALUE_W-1:0]  hold_predict;
  logic [sdicp_pkg::VALUE_W-1:0]  hold_assist;

  int failures;
  int checked;
  int updates;

  task automatic wipe_command();
    digits_acc   = '0;
    minus_sign   = 1'b0;
    phase        = sdicp_pkg::PH_SKIP;
    kept_chars   = '0;
    nfields      = '0;
    saw_zero     = 1'b0;
    newline_seen = 1'b0;
    field1       = '0;
    field2       = '0;
  endtask

  task automatic close_field();
    logic [sdicp_pkg::VALUE_W-1:0] val;
    val = minus_sign ? -{1'b0, digits_acc} : {1'b0, digits_acc};
    // Fields past the limit are neither counted nor checked for zero.
    if (nfields < MAX_FIELDS) begin
      if (nfields == 0) begin
        field1 = val;
      end else if (nfields == 1) begin
        field2 = val;
      end
      if (val == '0) begin
        saw_zero = 1'b1;
      end
      nfields = nfields + 1'b1;
    end
    digits_acc = '0;
    minus_sign = 1'b0;
    phase      = sdicp_pkg::PH_SKIP;
    kept_chars = '0;
  endtask

  task automatic parse_item(input sdicp_pkg::action_e act, input logic [7:0] ch);
    logic    is_digit;
    logic    is_space;
    status_t want;
    is_digit = (ch >= sdicp_pkg::CHAR_ZERO) && (ch <= sdicp_pkg::CHAR_NINE);
    is_space = (ch == sdicp_pkg::CHAR_SPACE) ||
               (ch >= sdicp_pkg::CHAR_TAB && ch <= sdicp_pkg::CHAR_CR);
    if (act == sdicp_pkg::ACT_BYTE) begin
      if (!newline_seen) begin
        if (ch == sdicp_pkg::CHAR_SLASH) begin
          close_field();
        end else if (ch == sdicp_pkg::CHAR_NL) begin
          close_field();
          newline_seen = 1'b1;
        end else if (kept_chars < FIELD_CHARS) begin
          kept_chars = kept_chars + 1'b1;
          case (phase)
            sdicp_pkg::PH_SKIP: begin
              if (!is_space) begin
                if (ch == sdicp_pkg::CHAR_PLUS) begin
                  phase = sdicp_pkg::PH_DIGITS;
                end else if (ch == sdicp_pkg::CHAR_MINUS) begin
                  minus_sign = 1'b1;
                  phase      = sdicp_pkg::PH_DIGITS;
                end else if (is_digit) begin
                  digits_acc = sdicp_pkg::ACCUM_W'(ch - sdicp_pkg::CHAR_ZERO);
                  phase      = sdicp_pkg::PH_DIGITS;
                end else begin
                  phase = sdicp_pkg::PH_DONE;
                end
              end
            end
            sdicp_pkg::PH_DIGITS: begin
              if (is_digit) begin
                digits_acc = digits_acc * sdicp_pkg::ACCUM_W'(10) +
                             sdicp_pkg::ACCUM_W'(ch - sdicp_pkg::CHAR_ZERO);
              end else begin
                phase = sdicp_pkg::PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end else begin
      want.updated = (nfields != '0) && !saw_zero;
      if (want.updated) begin
        hold_predict = field1;
        if (nfields >= 2) begin
          hold_assist = field2;
        end
      end
      want.predict = hold_predict;
      want.assist  = hold_assist;
      want.fields  = nfields;
      status_q.push_back(want);
      wipe_command();
    end
  endtask

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("%0t checker: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin
    status_t want;
    if (!rst_ni) begin
      wipe_command();
      hold_predict = '0;
      hold_assist  = '0;
      status_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        parse_item(sdicp_pkg::action_e'(action_i), rx_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          log_failure("result transaction with no command waiting for it");
        end else begin
          want = status_q.pop_front();
          checked++;
          if (updated_i) begin
            updates++;
          end
          if (updated_i !== want.updated) begin
            log_failure($sformatf("updated: expected %0d, got %0d",
                                  want.updated, updated_i));
          end
          if (pred_time_i !== want.predict) begin
            log_failure($sformatf("pred_time: expected %0d, got %0d",
                                  $signed(want.predict), pred_time_i));
          end
          if (assist_tenths_i !== want.assist) begin
            log_failure($sformatf("assist_tenths: expected %0d, got %0d",
                                  $signed(want.assist), assist_tenths_i));
          end
          if (fields_seen_i !== want.fields) begin
            log_failure($sformatf("fields_seen: expected %0d, got %0d",
                                  want.fields, fields_seen_i));
          end
        end
      end
    end
    fail_count_o      <= failures;
    pending_o         <= status_q.size();
    results_checked_o <= checked;
    updates_seen_o    <= updates;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives command bytes and line-idle events into the slash-delimited parser,
// with random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FIELD_CHARS   = 9;
  localparam int unsigned MAX_FIELDS    = 50;
  localparam int          ITEM_TARGET   = 1500;
  localparam int          CALM_AFTER    = 1300;
  localparam int          IDLE_LIMIT    = 200;
  localparam int          SETTLE_CYCLES = 10;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 action_i    = sdicp_pkg::ACT_BYTE;
  logic [7:0]                           rx_byte_i   = '0;
  logic                                 out_ready_i = 1'b1;
  logic                                 in_ready_o;
  logic                                 out_valid_o;
  logic                                 updated_o;
  logic signed [sdicp_pkg::VALUE_W-1:0] pred_time_o;
  logic signed [sdicp_pkg::VALUE_W-1:0] assist_tenths_o;
  logic [sdicp_pkg::FIELDS_W-1:0]       fields_seen_o;

  int fail_count;
  int pending;
  int results_checked;
  int updates_seen;

  int bytes_sent    = 0;
  int commands_sent = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  bit gaps_on       = 1'b1;

  always #6 clk_i = ~clk_i;

  slash_delimited_int_command_parser #(
    .FIELD_CHARS(FIELD_CHARS),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .updated_o      (updated_o),
    .pred_time_o    (pred_time_o),
    .assist_tenths_o(assist_tenths_o),
    .fields_seen_o  (fields_seen_o)
  );

  sdicp_checker #(
    .FIELD_CHARS(FIELD_CHARS),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .updated_i        (updated_o),
    .pred_time_i      (pred_time_o),
    .assist_tenths_i  (assist_tenths_o),
    .fields_seen_i    (fields_seen_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_checked_o(results_checked),
    .updates_seen_o   (updates_seen)
  );

  // Result side: random stall bursts while gaps are enabled.
  always @(negedge clk_i) begin
    if (!gaps_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input sdicp_pkg::action_e act, input logic [7:0] ch);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (act == sdicp_pkg::ACT_BYTE) begin
      bytes_sent++;
    end else begin
      commands_sent++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(sdicp_pkg::ACT_BYTE, s[i]);
    end
  endtask

  // Mostly well-formed commands with random content, some pure noise.
  task automatic send_random_command();
    logic [7:0] cmd_q[$];
    int         kind;
    int         nf;
    int         nd;
    int         sign_pick;
    bit         all_nines;
    bit         zero_field;
    int         d;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      nd = $urandom_range(0, 8);
      repeat (nd) cmd_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      nf = (kind < 15) ? $urandom_range(48, 55) : $urandom_range(1, 4);
      for (int j = 0; j < nf; j++) begin
        if (j > 0) begin
          cmd_q.push_back(sdicp_pkg::CHAR_SLASH);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 2) == 0) begin
              cmd_q.push_back(sdicp_pkg::CHAR_SPACE);
            end else begin
              cmd_q.push_back(sdicp_pkg::CHAR_TAB + 8'($urandom_range(0, 4)));
            end
          end
        end
        sign_pick = $urandom_range(0, 3);
        if (sign_pick == 0) begin
          cmd_q.push_back(sdicp_pkg::CHAR_PLUS);
        end else if (sign_pick == 1) begin
          cmd_q.push_back(sdicp_pkg::CHAR_MINUS);
        end
        nd = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
        if ($urandom_range(0, 15) == 0) begin
          nd = 0;
        end
        all_nines  = ($urandom_range(0, 9) == 0);
        zero_field = ($urandom_range(0, 24) == 0);
        for (int i = 0; i < nd; i++) begin
          if (zero_field) begin
            d = 0;
          end else if (all_nines) begin
            d = 9;
          end else begin
            d = (i == 0) ? $urandom_range(1, 9) : $urandom_range(0, 9);
          end
          cmd_q.push_back(sdicp_pkg::CHAR_ZERO + 8'(d));
        end
        if ($urandom_range(0, 9) == 0) begin
          cmd_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        cmd_q.push_back(sdicp_pkg::CHAR_NL);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) cmd_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
    foreach (cmd_q[i]) begin
      send_item(sdicp_pkg::ACT_BYTE, cmd_q[i]);
    end
    send_item(sdicp_pkg::ACT_IDLE, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Idle with no bytes at all: no fields.
    send_item(sdicp_pkg::ACT_IDLE, 8'h00);
    // Leading blank, minus sign, a single field, then a byte after the newline.
    send_text(" -7\n5");
    send_item(sdicp_pkg::ACT_IDLE, 8'hFF);
    // Ten nines: the tenth is dropped. Second field carries a plus sign.
    send_text("9999999999/+5\n");
    send_item(sdicp_pkg::ACT_IDLE, 8'h00);
    // A NUL byte stops the digits of the field.
    send_text("3");
    send_item(sdicp_pkg::ACT_BYTE, 8'h00);
    send_text("4\n");
    send_item(sdicp_pkg::ACT_IDLE, 8'h00);
    // No newline: the unfinished trailing field is never closed or counted.
    send_text("8/x");
    send_item(sdicp_pkg::ACT_IDLE, 8'h00);

    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= CALM_AFTER) begin
        gaps_on = 1'b0;
      end
      if (!paused && bytes_sent >= ITEM_TARGET / 2) begin
        // Hold off until every outstanding result has been drained.
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        paused = 1'b1;
      end
      send_random_command();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d command bytes and %0d line-idle events sent, %0d results checked",
             bytes_sent, commands_sent, results_checked);
    $display("summary: %0d commands refreshed the held values", updates_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== slash_delimited_int_command_parser.f =====
src/sdicp_pkg.sv
src/sdicp_field.sv
src/slash_delimited_int_command_parser.sv
tb/sdicp_checker.sv
tb/tb_top.sv
